[rtl/core/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants
// Sizes, mode and status codes, and the control word that drives the row of
// list cells.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int DEPTH         = 16;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 8;
   localparam int ENTRY_COUNT_W = 5;
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int CMP_W         = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_DUMP   = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic [CNT_W-1:0]          pos;
      logic [CNT_W-1:0]          cnt;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

[rtl/core/pli_cell.sv]
// ----------------------------------------------------------------------------
// pli_cell: one list slot
// Holds one entry and each cycle keeps it, loads the broadcast value, or
// takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module pli_cell (
   input  logic                              clock,
   input  pli_pkg::cell_ctl_type             ctl,
   input  logic [pli_pkg::CNT_W-1:0]         index,
   input  logic signed [pli_pkg::VALUE_W-1:0] left_value,
   input  logic signed [pli_pkg::VALUE_W-1:0] right_value,
   output logic signed [pli_pkg::VALUE_W-1:0] entry_ff
);

   logic signed [pli_pkg::VALUE_W-1:0] entry_in;
   logic [pli_pkg::CNT_W:0]            index_next;

   assign index_next = {1'b0, index} + {{pli_pkg::CNT_W{1'b0}}, 1'b1};

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         pli_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         pli_pkg::CELL_INSERT: begin
            if (index == ctl.pos) begin
               entry_in = ctl.value;
            end else if (index > ctl.pos && index <= ctl.cnt) begin
               entry_in = left_value;
            end
         end
         pli_pkg::CELL_DELETE: begin
            if (index >= ctl.pos && index_next < {1'b0, ctl.cnt}) begin
               entry_in = right_value;
            end
         end
         pli_pkg::CELL_ROTATE: begin
            // head entry wraps around to the tail of the used part
            if (index_next < {1'b0, ctl.cnt}) begin
               entry_in = right_value;
            end else if (index_next == {1'b0, ctl.cnt}) begin
               entry_in = ctl.value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/core/positional_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with positional insert/delete
// Row of entry cells under a small controller with a registered result word.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; an insert or delete shifts all
// cells at once and gives one result word. A dump gives one word per entry,
// one per cycle while the result register is free, by rotating the used
// cells through the head cell; after count rotations the list is back in
// order. A dump of an empty list gives a single word, and no new request
// is taken until the last word of a dump is registered. Each word shows up
// on the response side the cycle after it is made. There is a single result
// register: a new request is taken only when that register is empty or its
// word is taken in the same cycle, so a stalled response side holds off the
// request side, and a dump waits while the response side stalls.
module positional_list_insert_delete (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [pli_pkg::POS_W-1:0]           req_position,
   input  logic signed [pli_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pli_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [pli_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);

   pli_pkg::state_type                   state_ff, state_in;
   logic [pli_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [pli_pkg::CNT_W-1:0]            remaining_ff, remaining_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [pli_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [pli_pkg::CNT_W-1:0]            rsp_count_ff, rsp_count_in;
   logic [1:0]                           rsp_status_ff, rsp_status_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 rsp_load;

   pli_pkg::cell_ctl_type                ctl;
   logic signed [pli_pkg::VALUE_W-1:0]   entries [pli_pkg::DEPTH];

   logic                                 slot_free;
   logic                                 accept;
   logic [pli_pkg::CMP_W-1:0]            pos_ext;
   logic [pli_pkg::CMP_W-1:0]            cnt_ext;
   logic [pli_pkg::CNT_W-1:0]            pos_clamp;
   logic                                 full;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == pli_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign pos_ext   = pli_pkg::CMP_W'(req_position);
   assign cnt_ext   = pli_pkg::CMP_W'(count_ff);
   assign pos_clamp = (pos_ext > cnt_ext) ? count_ff : pli_pkg::CNT_W'(req_position);
   assign full      = (count_ff == pli_pkg::CNT_W'(pli_pkg::DEPTH));

   for (genvar i = 0; i < pli_pkg::DEPTH; i++) begin : g_cell
      logic signed [pli_pkg::VALUE_W-1:0] left_value;
      logic signed [pli_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value = '0;
      end else begin : g_body
         assign left_value = entries[i-1];
      end

      if (i == pli_pkg::DEPTH - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = entries[i+1];
      end

      pli_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .index       (pli_pkg::CNT_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_ff    (entries[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_count_in  = count_ff;
      rsp_status_in = pli_pkg::STATUS_DONE;
      rsp_last_in   = 1'b1;
      ctl.op        = pli_pkg::CELL_HOLD;
      ctl.pos       = pos_clamp;
      ctl.cnt       = count_ff;
      ctl.value     = req_value;

      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               unique case (req_mode)
                  pli_pkg::MODE_INSERT: begin
                     if (full) begin
                        rsp_status_in = pli_pkg::STATUS_FULL;
                     end else begin
                        ctl.op       = pli_pkg::CELL_INSERT;
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = count_in;
                     end
                  end
                  pli_pkg::MODE_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = pli_pkg::STATUS_RANGE;
                     end else begin
                        ctl.op       = pli_pkg::CELL_DELETE;
                        count_in     = count_ff - 1'b1;
                        rsp_count_in = count_in;
                     end
                  end
                  pli_pkg::MODE_DUMP: begin
                     if (count_ff != '0) begin
                        // first word comes from the head cell, then rotate
                        ctl.op       = pli_pkg::CELL_ROTATE;
                        ctl.value    = entries[0];
                        rsp_value_in = entries[0];
                        rsp_last_in  = (count_ff == pli_pkg::CNT_W'(1));
                        remaining_in = count_ff - 1'b1;
                        if (count_ff != pli_pkg::CNT_W'(1)) begin
                           state_in = pli_pkg::ST_DUMP;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = pli_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         pli_pkg::ST_DUMP: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               ctl.op       = pli_pkg::CELL_ROTATE;
               ctl.value    = entries[0];
               rsp_value_in = entries[0];
               rsp_last_in  = (remaining_ff == pli_pkg::CNT_W'(1));
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == pli_pkg::CNT_W'(1)) begin
                  state_in = pli_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_count = pli_pkg::ENTRY_COUNT_W'(rsp_count_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_list_insert_delete
// Sends insert, delete, dump and unused-mode words through the request
// channel and predicts every response word from a shadow copy of the list.
// Responses are compared field by field, in order. The run steps through
// phases with different idle and stall rates, and one phase where the
// response side holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] MODE_NOP    = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         LONG_HOLD   = 300;

   typedef struct {
      logic [1:0]                         mode;
      logic [pli_pkg::POS_W-1:0]          pos;
      logic signed [pli_pkg::VALUE_W-1:0] value;
   } list_op_type;

   typedef struct {
      logic signed [pli_pkg::VALUE_W-1:0] value;
      logic [pli_pkg::ENTRY_COUNT_W-1:0]  count;
      logic [1:0]                         status;
      logic                               last;
   } list_word_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [1:0]                           req_mode = pli_pkg::MODE_INSERT;
   logic [pli_pkg::POS_W-1:0]            req_position = '0;
   logic signed [pli_pkg::VALUE_W-1:0]   req_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [pli_pkg::VALUE_W-1:0]   rsp_entry_value;
   logic [pli_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count;
   logic [1:0]                           rsp_status;
   logic                                 rsp_last;

   list_op_type   ops_to_send[$];
   list_word_type list_words_due[$];

   // shadow of the list used to predict responses
   logic signed [pli_pkg::VALUE_W-1:0] list_entries [pli_pkg::DEPTH];
   int                                 list_count = 0;

   // count tracked while generating, to steer random sequences
   int          planned_count = 0;
   bit          filling = 1'b1;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_rsp = 1'b0;
   bit          req_fire = 1'b0;
   int          errors = 0;
   int          cycle_count = 0;

   positional_list_insert_delete uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   always #6 clock = ~clock;

   task automatic push_word_due(input logic signed [pli_pkg::VALUE_W-1:0] value,
                                input logic [1:0] status, input logic last);
      list_word_type w;
      w.value  = value;
      w.count  = list_count[pli_pkg::ENTRY_COUNT_W-1:0];
      w.status = status;
      w.last   = last;
      list_words_due.push_back(w);
   endtask

   task automatic apply_list_op(input list_op_type op);
      int i;
      int p;
      p = op.pos;
      case (op.mode)
         pli_pkg::MODE_INSERT: begin
            if (list_count >= pli_pkg::DEPTH) begin
               push_word_due('0, pli_pkg::STATUS_FULL, 1'b1);
            end else begin
               if (p > list_count) p = list_count;
               for (i = list_count; i > p; i--) list_entries[i] = list_entries[i-1];
               list_entries[p] = op.value;
               list_count++;
               push_word_due('0, pli_pkg::STATUS_DONE, 1'b1);
            end
         end
         pli_pkg::MODE_DELETE: begin
            if (p >= list_count) begin
               push_word_due('0, pli_pkg::STATUS_RANGE, 1'b1);
            end else begin
               for (i = p; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
               list_count--;
               push_word_due('0, pli_pkg::STATUS_DONE, 1'b1);
            end
         end
         pli_pkg::MODE_DUMP: begin
            if (list_count == 0) begin
               push_word_due('0, pli_pkg::STATUS_DONE, 1'b1);
            end else begin
               for (i = 0; i < list_count; i++)
                  push_word_due(list_entries[i], pli_pkg::STATUS_DONE, i + 1 == list_count);
            end
         end
         default: push_word_due('0, pli_pkg::STATUS_DONE, 1'b1);
      endcase
   endtask

   task automatic queue_op(input logic [1:0] mode, input int pos,
                           input logic signed [pli_pkg::VALUE_W-1:0] value);
      list_op_type op;
      op.mode  = mode;
      op.pos   = pos[pli_pkg::POS_W-1:0];
      op.value = value;
      ops_to_send.push_back(op);
      if (mode == pli_pkg::MODE_INSERT && planned_count < pli_pkg::DEPTH) planned_count++;
      if (mode == pli_pkg::MODE_DELETE && pos < planned_count) planned_count--;
   endtask

   task automatic queue_random_ops(input int n);
      int k;
      int r;
      int pos;
      logic [1:0] mode;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 2) begin
            mode = MODE_NOP;
         end else if (r < 12) begin
            mode = pli_pkg::MODE_DUMP;
         end else if (r < 17) begin
            mode = $urandom_range(1) ? pli_pkg::MODE_DELETE : pli_pkg::MODE_INSERT;
         end else if ($urandom_range(99) < 80) begin
            mode = filling ? pli_pkg::MODE_INSERT : pli_pkg::MODE_DELETE;
         end else begin
            mode = filling ? pli_pkg::MODE_DELETE : pli_pkg::MODE_INSERT;
         end
         if (r < 17 || $urandom_range(99) < 15) begin
            pos = $urandom_range(255);
         end else if (mode == pli_pkg::MODE_DELETE) begin
            pos = (planned_count == 0) ? 0 : $urandom_range(planned_count - 1);
         end else begin
            pos = $urandom_range(planned_count);
         end
         queue_op(mode, pos, $urandom);
         // turn around at the ends so both full and empty get exercised
         if (planned_count == pli_pkg::DEPTH && $urandom_range(3) == 0) filling = 1'b0;
         if (planned_count == 0 && $urandom_range(1) == 0) filling = 1'b1;
      end
   endtask

   task automatic drain_list_words;
      while (ops_to_send.size() != 0 || req_valid || list_words_due.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      list_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op = ops_to_send.pop_front();
            req_valid    <= 1'b1;
            req_mode     <= op.mode;
            req_position <= op.pos;
            req_value    <= op.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side ready
   always @(negedge clock) begin
      rsp_ready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin : watch
      list_op_type   op;
      list_word_type w;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            op.mode  = req_mode;
            op.pos   = req_position;
            op.value = req_value;
            apply_list_op(op);
         end
         if (rsp_valid && rsp_ready) begin
            if (list_words_due.size() == 0) begin
               $display("%0t: unexpected word: value %0d count %0d status %0d last %0d",
                        $time, rsp_entry_value, rsp_entry_count, rsp_status, rsp_last);
               errors++;
            end else begin
               w = list_words_due.pop_front();
               if (rsp_entry_value !== w.value) begin
                  $display("%0t: entry_value expected %0d actual %0d",
                           $time, w.value, rsp_entry_value);
                  errors++;
               end
               if (rsp_entry_count !== w.count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, w.count, rsp_entry_count);
                  errors++;
               end
               if (rsp_status !== w.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, w.status, rsp_status);
                  errors++;
               end
               if (rsp_last !== w.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, w.last, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int k;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list corners, extremes, fill to full, deletes
      queue_op(pli_pkg::MODE_DUMP, 0, '0);
      queue_op(pli_pkg::MODE_DELETE, 0, '0);
      queue_op(MODE_NOP, 255, $urandom);
      queue_op(pli_pkg::MODE_INSERT, 0, 32'sh8000_0000);
      queue_op(pli_pkg::MODE_INSERT, 255, 32'sh7fff_ffff);
      queue_op(pli_pkg::MODE_INSERT, 0, -32'sd1);
      for (k = 0; k < pli_pkg::DEPTH - 3; k++)
         queue_op(pli_pkg::MODE_INSERT, $urandom_range(planned_count), $urandom);
      queue_op(pli_pkg::MODE_INSERT, 3, $urandom);
      queue_op(pli_pkg::MODE_DUMP, 0, '0);
      queue_op(pli_pkg::MODE_DELETE, pli_pkg::DEPTH - 1, '0);
      queue_op(pli_pkg::MODE_DELETE, 0, '0);
      queue_op(pli_pkg::MODE_DELETE, 200, '0);
      queue_op(pli_pkg::MODE_DELETE, 7, '0);
      queue_op(pli_pkg::MODE_DUMP, 0, '0);
      drain_list_words();

      queue_random_ops(54);
      drain_list_words();

      send_idle_pct = 86;
      queue_random_ops(60);
      drain_list_words();

      send_idle_pct  = 0;
      recv_stall_pct = 86;
      queue_random_ops(60);
      drain_list_words();

      send_idle_pct  = 8;
      recv_stall_pct = 8;
      queue_random_ops(70);
      drain_list_words();

      // response side holds off while requests keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      queue_random_ops(40);
      drain_list_words();

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
